[rtl/bse_pkg.sv]
`default_nettype none

package bse_pkg;

  // Fixed-point format of coordinates: signed Q5.27 in 32 bits.
  localparam int FracBits = 27;
  localparam int QWidth   = 32;

  // Largest image the index clamp allows.
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // Configuration register indexes.
  localparam logic [2:0] RegXMin      = 3'd0;
  localparam logic [2:0] RegYMax      = 3'd1;
  localparam logic [2:0] RegStepX     = 3'd2;
  localparam logic [2:0] RegStepY     = 3'd3;
  localparam logic [2:0] RegIterLimit = 3'd4;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] XMinReset      = -32'sd335544320;
  localparam logic signed [31:0] YMaxReset      = 32'sd134217728;
  localparam logic        [27:0] StepXReset     = 28'd524288;
  localparam logic        [27:0] StepYReset     = 28'd524288;
  localparam logic        [15:0] IterLimitReset = 16'd256;

  // Escape threshold 4.0 in Q.27.
  localparam logic [36:0] EscapeLimit = 37'(64'd4 << FracBits);

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] y_max;
    logic        [27:0] step_x;
    logic        [27:0] step_y;
    logic        [15:0] iter_limit;
  } cfg_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_CX,
    MUL_CY,
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_sel_t;

  typedef struct packed {
    logic     load;    // latch a new pixel and clear z
    mul_sel_t mul_sel;
    logic     ld_cx;
    logic     ld_cy;
    logic     ld_xx;
    logic     ld_yy;
    logic     step;    // commit the new z and count the iteration
    logic     finish;  // register the result word
  } dp_cmd_t;

  typedef struct packed {
    logic stop;        // escaped or reached the limit
  } dp_stat_t;

  // Saturate a 42-bit signed sum to Q5.27.
  function automatic logic signed [31:0] sat_q(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) begin
      sat_q = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat_q = 32'sh8000_0000;
    end else begin
      sat_q = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/bse_cfg.sv]
`default_nettype none

module bse_cfg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  output bse_pkg::cfg_t         cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min      <= bse_pkg::XMinReset;
      cfg.y_max      <= bse_pkg::YMaxReset;
      cfg.step_x     <= bse_pkg::StepXReset;
      cfg.step_y     <= bse_pkg::StepYReset;
      cfg.iter_limit <= bse_pkg::IterLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bse_pkg::RegXMin:      cfg.x_min      <= cfg_data;
        bse_pkg::RegYMax:      cfg.y_max      <= cfg_data;
        bse_pkg::RegStepX:     cfg.step_x     <= cfg_data[27:0];
        bse_pkg::RegStepY:     cfg.step_y     <= cfg_data[27:0];
        bse_pkg::RegIterLimit: cfg.iter_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bse_ctrl.sv]
`default_nettype none

module bse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire bse_pkg::dp_stat_t stat,
  output bse_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX,
    S_CY,
    S_CY_ADD,
    S_SQX,
    S_SQY,
    S_XY,
    S_TEST
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (start) state <= S_CX;
        S_CX:     state <= S_CY;
        S_CY:     state <= S_CY_ADD;
        S_CY_ADD: state <= S_SQX;
        S_SQX:    state <= S_SQY;
        S_SQY:    state <= S_XY;
        S_XY:     state <= S_TEST;
        S_TEST:   state <= stat.stop ? S_IDLE : S_SQX;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = bse_pkg::MUL_XX;
    case (state)
      S_IDLE: cmd.load = start;
      S_CX:   cmd.mul_sel = bse_pkg::MUL_CX;
      S_CY: begin
        cmd.mul_sel = bse_pkg::MUL_CY;
        cmd.ld_cx   = 1'b1;
      end
      S_CY_ADD: cmd.ld_cy = 1'b1;
      S_SQX:    cmd.mul_sel = bse_pkg::MUL_XX;
      S_SQY: begin
        cmd.mul_sel = bse_pkg::MUL_YY;
        cmd.ld_xx   = 1'b1;
      end
      S_XY: begin
        cmd.mul_sel = bse_pkg::MUL_XY;
        cmd.ld_yy   = 1'b1;
      end
      S_TEST: begin
        cmd.step   = !stat.stop;
        cmd.finish = stat.stop;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/bse_dp.sv]
`default_nettype none

module bse_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bse_pkg::cfg_t     cfg,
  input  wire bse_pkg::dp_cmd_t  cmd,
  output bse_pkg::dp_stat_t      stat,
  input  wire logic [11:0]       column,
  input  wire logic [11:0]       row,
  output logic                   done,
  output logic [15:0]            iterations,
  output logic                   inside_res,
  output logic [33:0]            final_magnitude
);

  logic [11:0]        col_q;
  logic [11:0]        row_q;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] zx;
  logic signed [31:0] zy;
  logic [15:0]        iter;
  logic [63:0]        prod;
  logic [35:0]        xx;
  logic [35:0]        yy;

  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [16:0]        col_ext;
  logic [16:0]        row_ext;
  logic [11:0]        col_clamp;
  logic [11:0]        row_clamp;
  logic signed [41:0] cx_sum;
  logic signed [41:0] cy_sum;
  logic signed [37:0] zx_sum;
  logic signed [37:0] zy_sum;
  logic [36:0]        mag2;
  logic               limit_hit;

  // Indexes past the image edge clamp to the last column or row.
  assign col_ext   = {5'd0, column};
  assign row_ext   = {5'd0, row};
  assign col_clamp = (col_ext >= 17'(bse_pkg::MaxWidth))  ? 12'(bse_pkg::MaxWidth - 1)  : column;
  assign row_clamp = (row_ext >= 17'(bse_pkg::MaxHeight)) ? 12'(bse_pkg::MaxHeight - 1) : row;

  // Magnitudes; the most negative value maps to 2^31, which fits unsigned.
  assign ax = zx[31] ? 32'(-zx) : 32'(zx);
  assign ay = zy[31] ? 32'(-zy) : 32'(zy);

  always_comb begin
    case (cmd.mul_sel)
      bse_pkg::MUL_CX: begin
        op_a = {20'd0, col_q};
        op_b = {4'd0, cfg.step_x};
      end
      bse_pkg::MUL_CY: begin
        op_a = {20'd0, row_q};
        op_b = {4'd0, cfg.step_y};
      end
      bse_pkg::MUL_XX: begin
        op_a = ax;
        op_b = ax;
      end
      bse_pkg::MUL_YY: begin
        op_a = ay;
        op_b = ay;
      end
      bse_pkg::MUL_XY: begin
        op_a = ax;
        op_b = ay;
      end
      default: begin
        op_a = ax;
        op_b = ax;
      end
    endcase
  end

  // The index times step product reaches almost 2^40, so the sums need 42 bits.
  assign cx_sum = $signed({{10{cfg.x_min[31]}}, cfg.x_min}) + $signed({2'b00, prod[39:0]});
  assign cy_sum = $signed({{10{cfg.y_max[31]}}, cfg.y_max}) - $signed({2'b00, prod[39:0]});

  // New z: the products are floors of non-negative values, so truncation is a shift.
  assign zx_sum = $signed({2'b00, xx}) - $signed({2'b00, yy}) + {{6{cx[31]}}, cx};
  assign zy_sum = $signed({1'b0, prod[62:26]}) + {{6{cy[31]}}, cy};

  assign mag2      = {1'b0, xx} + {1'b0, yy};
  assign limit_hit = (iter >= cfg.iter_limit);
  assign stat.stop = (mag2 >= bse_pkg::EscapeLimit) || limit_hit;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.load) begin
      col_q <= col_clamp;
      row_q <= row_clamp;
      zx    <= '0;
      zy    <= '0;
      iter  <= '0;
    end
    if (cmd.ld_cx) cx <= bse_pkg::sat_q(cx_sum);
    if (cmd.ld_cy) cy <= bse_pkg::sat_q(cy_sum);
    if (cmd.ld_xx) xx <= prod[62:27];
    if (cmd.ld_yy) yy <= prod[62:27];
    if (cmd.step) begin
      zx   <= bse_pkg::sat_q({{4{zx_sum[37]}}, zx_sum});
      zy   <= bse_pkg::sat_q({{4{zy_sum[37]}}, zy_sum});
      iter <= iter + 16'd1;
    end
    if (cmd.finish) begin
      iterations      <= iter;
      inside_res      <= limit_hit;
      final_magnitude <= (mag2[36:34] != 3'd0) ? {34{1'b1}} : mag2[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

`default_nettype wire

[rtl/burning_ship_escape_time_top.sv]
`default_nettype none

// Burning Ship escape-time engine, one pixel at a time.
// Each iteration makes three passes of the one shared 32x32 multiplier (zx^2, zy^2, zx*zy)
// and one step to test and update; a new pixel is taken only once the engine is idle.
// Reset (rst, synchronous, active high) idles the engine and restores the default view.
// The result word is shown for one cycle with done high; the receiver cannot stall it.

module burning_ship_escape_time_top (
  input  wire logic        clk,
  input  wire logic        rst,

  // Pixel command: taken when start is high and busy is low.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] column,
  input  wire logic [11:0] row,

  // Result word, valid for the single cycle in which done is high.
  output logic             done,
  output logic [15:0]      iterations,
  output logic             inside_res,
  output logic [33:0]      final_magnitude,

  // Configuration writes: register index and data, taken when valid and ready.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  bse_pkg::cfg_t     cfg;
  bse_pkg::dp_cmd_t  cmd;
  bse_pkg::dp_stat_t stat;

  // The register file holds the view window and the iteration limit. Software must write it
  // only while the engine is idle; the block does not enforce this, and the datapath reads it directly.
  bse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller first forms c with two multiplier passes, then loops through the
  // square, square, cross product and test steps until the point escapes or the
  // iteration count reaches the limit.
  bse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds c, z, the iteration count and the registered product. Every new
  // coordinate saturates to Q5.27, and the reported magnitude saturates at 34 bits.
  bse_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .column          (column),
    .row             (row),
    .done            (done),
    .iterations      (iterations),
    .inside_res      (inside_res),
    .final_magnitude (final_magnitude)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

// Testbench for the Burning Ship escape-time engine.
//
// Pixel words go in through the start/busy command port. Each accepted pixel is run
// through a behavioral predictor at the moment it is taken, using a local copy of the
// view registers. The expected word is queued. The checker pops the oldest expected
// word each time done is high and compares it field by field.
//
// The engine cannot hold its results off. All pacing therefore happens on the sender
// side: random gaps between pixels, phases with no gaps, and occasional full drains.
// View registers are only rewritten after a drain, when the engine is idle.

module tb;

  // The slowest pixel runs 65535 engine iterations. The watchdog must outlast that single
  // quiet stretch several times over.
  localparam int unsigned WatchdogLimit = 1_000_000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned ReportLimit   = 50;

  localparam longint     QOne           = longint'(1) << bse_pkg::FracBits;
  localparam longint     QMax           = 64'sd2147483647;
  localparam longint     QMin           = -64'sd2147483648;
  localparam logic [33:0] MagMax        = '1;
  localparam logic [2:0] RegFirstUnused = bse_pkg::RegIterLimit + 3'd1;

  // The word that comes back for each pixel.
  typedef struct packed {
    logic [15:0] iterations;
    logic        in_set;
    logic [33:0] magnitude;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [11:0] column;
  logic [11:0] row;
  logic        done;
  logic [15:0] iterations;
  logic        inside_res;
  logic [33:0] final_magnitude;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // The view registers as the engine should hold them right now.
  bse_pkg::cfg_t view_cfg;
  // Expected words, oldest first.
  pixel_res_t  pending_pixels[$];
  pixel_res_t  due;
  int unsigned errors;
  int unsigned quiet_cycles;
  // When set, the sender offers pixels back to back with no gaps.
  bit          steady;

  always #5 clk = ~clk;

  burning_ship_escape_time_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .column          (column),
    .row             (row),
    .done            (done),
    .iterations      (iterations),
    .inside_res      (inside_res),
    .final_magnitude (final_magnitude),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Prints one line per mismatch (up to a cap, so a broken engine does not flood the
  // log) and always counts it.
  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= ReportLimit) begin
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    end
  endtask

  // Saturate a wide signed sum to the Q5.27 coordinate range.
  function automatic longint clamp_q5_27(input longint v);
    if (v > QMax) begin
      return QMax;
    end
    if (v < QMin) begin
      return QMin;
    end
    return v;
  endfunction

  // Escape-time predictor for one pixel under the current view registers.
  // All squares are of magnitudes, so the right shifts are plain floors. |z|^2 is kept
  // at full width for the escape test and only clipped to 34 bits when reported.
  function automatic pixel_res_t escape_time(input logic [11:0] col, input logic [11:0] rw);
    int          c_idx;
    int          r_idx;
    longint      cx;
    longint      cy;
    longint      zx;
    longint      zy;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] xx;
    logic [63:0] yy;
    logic [63:0] xy2;
    logic [63:0] mag2;
    int unsigned n;
    pixel_res_t  r;
    c_idx = (int'(col) >= bse_pkg::MaxWidth) ? bse_pkg::MaxWidth - 1 : int'(col);
    r_idx = (int'(rw) >= bse_pkg::MaxHeight) ? bse_pkg::MaxHeight - 1 : int'(rw);
    cx = clamp_q5_27(longint'($signed(view_cfg.x_min))
                     + longint'(c_idx) * longint'(view_cfg.step_x));
    cy = clamp_q5_27(longint'($signed(view_cfg.y_max))
                     - longint'(r_idx) * longint'(view_cfg.step_y));
    zx = 0;
    zy = 0;
    n  = 0;
    forever begin
      ax   = (zx < 0) ? 64'(-zx) : 64'(zx);
      ay   = (zy < 0) ? 64'(-zy) : 64'(zy);
      xx   = (ax * ax) >> bse_pkg::FracBits;
      yy   = (ay * ay) >> bse_pkg::FracBits;
      mag2 = xx + yy;
      if (mag2 >= 64'(bse_pkg::EscapeLimit) || n >= view_cfg.iter_limit) begin
        break;
      end
      xy2 = (ax * ay) >> (bse_pkg::FracBits - 1);
      zx  = clamp_q5_27(longint'(xx) - longint'(yy) + cx);
      zy  = clamp_q5_27(longint'(xy2) + cy);
      n++;
    end
    // With a zero limit nothing runs and the magnitude is reported as zero.
    if (view_cfg.iter_limit == 16'd0) begin
      mag2 = '0;
    end
    r.iterations = 16'(n);
    r.in_set     = (n >= view_cfg.iter_limit);
    r.magnitude  = (mag2 > 64'(MagMax)) ? MagMax : mag2[33:0];
    return r;
  endfunction

  // Sender gaps: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) begin
      return 0;
    end
    if (r < 80) begin
      return $urandom_range(1, 3);
    end
    if (r < 96) begin
      return $urandom_range(4, 24);
    end
    return $urandom_range(40, 300);
  endfunction

  // Offers one pixel and returns at the rising edge where it was taken. start is left
  // high, so a following pixel replaces it at the next falling edge without a dip; any
  // other next step lowers it at that same falling edge, long before the engine could
  // take the word a second time.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw);
    @(negedge clk);
    start  <= 1'b1;
    column <= col;
    row    <= rw;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_pixels.push_back(escape_time(col, rw));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles == 0) begin
      return;
    end
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop offering and wait until every expected word has come back. Each pixel gives
  // exactly one word, so an empty queue means the engine is idle.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One register write; the local copy follows the width of each register.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      bse_pkg::RegXMin:      view_cfg.x_min      = data;
      bse_pkg::RegYMax:      view_cfg.y_max      = data;
      bse_pkg::RegStepX:     view_cfg.step_x     = data[27:0];
      bse_pkg::RegStepY:     view_cfg.step_y     = data[27:0];
      bse_pkg::RegIterLimit: view_cfg.iter_limit = data[15:0];
      default:      ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drains the engine, then rewrites the whole view. The unused upper bits of the
  // narrow registers carry random junk, which the engine must drop.
  task automatic set_view(input logic signed [31:0] x0, input logic signed [31:0] y0,
                          input logic [27:0] sx, input logic [27:0] sy,
                          input logic [15:0] lim);
    drain_results();
    write_reg(bse_pkg::RegXMin, x0);
    write_reg(bse_pkg::RegYMax, y0);
    write_reg(bse_pkg::RegStepX, {4'($urandom), sx});
    write_reg(bse_pkg::RegStepY, {4'($urandom), sy});
    write_reg(bse_pkg::RegIterLimit, {16'($urandom), lim});
  endtask

  // The view the engine comes out of reset with: corners, one pixel on the origin that
  // runs the full limit, and one near the edge of the set.
  task automatic test_default_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd640, 12'd256);
    send_pixel(12'd600, 12'd250);
  endtask

  // Zero limit, a limit of one, and the largest limit. The pixel on the origin never
  // escapes, so it shows the count running all the way to the top of its 16 bits.
  task automatic test_iteration_limits();
    set_view(bse_pkg::XMinReset, bse_pkg::YMaxReset, bse_pkg::StepXReset,
             bse_pkg::StepYReset, 16'd0);
    send_pixel(12'd640, 12'd256);
    send_pixel(12'd0, 12'd0);
    set_view(bse_pkg::XMinReset, bse_pkg::YMaxReset, bse_pkg::StepXReset,
             bse_pkg::StepYReset, 16'd1);
    send_pixel(12'd640, 12'd256);
    set_view(bse_pkg::XMinReset, bse_pkg::YMaxReset, bse_pkg::StepXReset,
             bse_pkg::StepYReset, 16'hFFFF);
    send_pixel(12'd640, 12'd256);
    send_pixel(12'd0, 12'd0);
  endtask

  // Views at the ends of the coordinate range: zero steps, unit steps and the widest
  // steps. These drive c into saturation on both sides and push |z|^2 past what
  // the 34-bit magnitude field can hold.
  task automatic test_view_extremes();
    set_view(32'sh8000_0000, 32'sh7FFF_FFFF, 28'd0, 28'd0, 16'd16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    set_view(32'sh7FFF_FFFF, 32'sh8000_0000, 28'(QOne), 28'(QOne), 16'd16);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    set_view(32'sh7FFF_FFFF, 32'sh8000_0000, 28'hFFF_FFFF, 28'hFFF_FFFF, 16'd16);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
  endtask

  // Writes to indexes past the last register must leave the view untouched.
  task automatic test_unknown_index();
    set_view(32'(-QOne), 32'(QOne / 2), 28'd1 << 18, 28'd1 << 18, 16'd40);
    for (int i = RegFirstUnused; i < (1 << $bits(cfg_index)); i++) begin
      write_reg(3'(i), $urandom);
    end
    send_pixel(12'd1024, 12'd1024);
    send_pixel(12'd2000, 12'd2500);
  endtask

  // Random views, each followed by a batch of random pixels. Most views sit on the
  // interesting part of the plane, so pixels land inside, outside and on the boundary.
  // A few views are anywhere at all, and some zoom in near the origin where almost
  // every pixel runs to the limit.
  task automatic test_random_scan(input int phases, input int per_phase);
    int unsigned        kind;
    int unsigned        r;
    int                 count;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic [27:0]        sx;
    logic [27:0]        sy;
    logic [15:0]        lim;
    for (int p = 0; p < phases; p++) begin
      kind = $urandom_range(0, 9);
      r    = $urandom_range(0, 99);
      if (r < 3) begin
        lim = 16'd0;
      end else if (r < 8) begin
        lim = 16'd1;
      end else if (r < 60) begin
        lim = 16'($urandom_range(2, 32));
      end else if (r < 88) begin
        lim = 16'($urandom_range(33, 100));
      end else begin
        lim = bse_pkg::IterLimitReset;
      end
      if (kind <= 6) begin
        x0 = 32'(-(5 * QOne) / 2 + longint'($urandom_range(0, 3 * QOne / 2)));
        y0 = 32'(longint'($urandom_range(0, 2 * QOne)));
        sx = 28'($urandom_range(1 << 14, 1 << 18));
        sy = 28'($urandom_range(1 << 14, 1 << 18));
      end else if (kind == 7) begin
        x0 = $urandom;
        y0 = $urandom;
        sx = 28'($urandom);
        sy = 28'($urandom);
      end else begin
        // Near the origin nearly every pixel is inside, so keep the limit modest.
        x0 = 32'(longint'($urandom_range(0, QOne / 2)) - QOne / 4);
        y0 = 32'(longint'($urandom_range(0, QOne / 2)) - QOne / 4);
        sx = 28'($urandom_range(0, 255));
        sy = 28'($urandom_range(0, 255));
        if (lim > 16'd64) begin
          lim = 16'd64;
        end
      end
      // Long limits make slow pixels, so those phases are kept short.
      count  = (lim > 16'd100) ? per_phase / 3 : per_phase;
      steady = ($urandom_range(0, 3) == 0);
      set_view(x0, y0, sx, sy, lim);
      for (int k = 0; k < count; k++) begin
        send_pixel(12'($urandom), 12'($urandom));
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end else begin
          idle_sender(pick_gap());
        end
      end
    end
    steady = 1'b0;
  endtask

  // Checker and watchdog. Outputs are sampled at the rising edge; everything the engine
  // drives changes through its own registers, so the values seen here are the ones the
  // edge is taking. The watchdog only counts cycles in which no word moves on any port.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_pixels.size() == 0) begin
          report("result word with no pixel outstanding", 64'd0, 64'd1);
        end else begin
          due = pending_pixels.pop_front();
          if (iterations !== due.iterations) begin
            report("iterations", 64'(due.iterations), 64'(iterations));
          end
          if (inside_res !== due.in_set) begin
            report("inside_res", 64'(due.in_set), 64'(inside_res));
          end
          if (final_magnitude !== due.magnitude) begin
            report("final_magnitude", 64'(due.magnitude), 64'(final_magnitude));
          end
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    column       = '0;
    row          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = bse_pkg::RegXMin;
    cfg_data     = '0;
    errors       = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    view_cfg     = '{x_min: bse_pkg::XMinReset, y_max: bse_pkg::YMaxReset,
                     step_x: bse_pkg::StepXReset, step_y: bse_pkg::StepYReset,
                     iter_limit: bse_pkg::IterLimitReset};
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_view();
    test_iteration_limits();
    test_view_extremes();
    test_unknown_index();
    test_random_scan(12, 150);

    // Let the last pixel finish, then give a stray late word a chance to show up.
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
